[rtl/wlh_pkg.sv]
package wlh_pkg;

    localparam int TASK_SLOTS = 1024;
    localparam int GROUPS     = 64;
    localparam int BINS       = 27;

    localparam int ACT_W      = 2;
    localparam int TASK_W     = 10;
    localparam int TS_W       = 64;
    localparam int GRP_W      = 6;
    localparam int BIN_W      = 5;
    localparam int STAT_W     = 3;
    localparam int SCALED_W   = 55;
    localparam int CNT_W      = 64;

    localparam int TASK_AW    = $clog2(TASK_SLOTS);
    localparam int GRP_AW     = $clog2(GROUPS);
    localparam int BIN_DEPTH  = GROUPS * BINS;
    localparam int BIN_AW     = $clog2(BIN_DEPTH);

    // clearing pass walks the deepest store, the others ride along
    localparam int CLEAR_LEN  = (BIN_DEPTH > TASK_SLOTS) ? BIN_DEPTH : TASK_SLOTS;
    localparam int CLR_W      = $clog2(CLEAR_LEN);

    localparam int NS_PER_US  = 1000;
    localparam int NS_PER_MS  = 1000000;

    // unit divisors split into a power of two and an odd factor
    localparam int US_PRE_SHIFT  = 3;
    localparam int MS_PRE_SHIFT  = 6;
    localparam int US_ODD        = NS_PER_US >> US_PRE_SHIFT;
    localparam int MS_ODD        = NS_PER_MS >> MS_PRE_SHIFT;
    localparam int US_POST_SHIFT = TS_W - US_PRE_SHIFT + $clog2(US_ODD);
    localparam int MS_POST_SHIFT = TS_W - MS_PRE_SHIFT + $clog2(MS_ODD);

    localparam int MUL_W      = TS_W / 2;
    localparam int PART_W     = 2 * MUL_W;
    localparam int PROD_W     = 2 * TS_W;
    localparam int MUL_STEPS  = 4;
    localparam int MUL_STEP_W = $clog2(MUL_STEPS);

    // rounded-up reciprocals; the odd factors never divide a power of two
    localparam logic [TS_W-1:0] US_RECIP =
        TS_W'((PROD_W'(1) << US_POST_SHIFT) / PROD_W'(US_ODD) + PROD_W'(1));
    localparam logic [TS_W-1:0] MS_RECIP =
        TS_W'((PROD_W'(1) << MS_POST_SHIFT) / PROD_W'(MS_ODD) + PROD_W'(1));

    localparam logic [ACT_W-1:0] ACT_WAKEUP = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SWITCH = 2'd1;
    localparam logic [ACT_W-1:0] ACT_READ   = 2'd2;

    localparam logic [STAT_W-1:0] STAT_RECORDED = 3'd0;
    localparam logic [STAT_W-1:0] STAT_MEASURED = 3'd1;
    localparam logic [STAT_W-1:0] STAT_NO_START = 3'd2;
    localparam logic [STAT_W-1:0] STAT_IGNORED  = 3'd3;
    localparam logic [STAT_W-1:0] STAT_READ     = 3'd4;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_DIV,
        S_BIN_RD,
        S_UPDATE
    } state_t;

    typedef struct packed {
        logic               rd_en;
        logic               wr_en;
        logic [TASK_AW-1:0] addr;
        logic               wr_valid;
        logic [TS_W-1:0]    wr_ts;
    } time_req_t;

    typedef struct packed {
        logic            valid;
        logic [TS_W-1:0] ts;
    } time_rsp_t;

    typedef struct packed {
        logic              bin_rd;
        logic              bin_wr;
        logic [BIN_AW-1:0] bin_addr;
        logic [CNT_W-1:0]  bin_wdata;
        logic              grp_rd;
        logic              grp_wr;
        logic [GRP_AW-1:0] grp_addr;
        logic [TS_W-1:0]   grp_wsum;
        logic [CNT_W-1:0]  grp_wcnt;
    } hist_req_t;

    typedef struct packed {
        logic [CNT_W-1:0] bin_count;
        logic [TS_W-1:0]  grp_sum;
        logic [CNT_W-1:0] grp_cnt;
    } hist_rsp_t;

    typedef struct packed {
        logic [SCALED_W-1:0] quotient;
        logic [BIN_W-1:0]    bin;
    } scale_res_t;

    function automatic logic [BIN_W-1:0] clamp_bin(input logic [BIN_W-1:0] sel);
        logic [BIN_W-1:0] res;
        res = sel;
        if (32'(sel) >= BINS)
            res = BIN_W'(BINS - 1);
        return res;
    endfunction

    function automatic logic [BIN_AW-1:0] bin_addr(input logic [GRP_W-1:0] grp,
                                                   input logic [BIN_W-1:0] bin);
        logic [BIN_AW-1:0] res;
        res = BIN_AW'(grp) * BIN_AW'(BINS) + BIN_AW'(bin);
        return res;
    endfunction

endpackage

[rtl/wlh_time_store.sv]
module wlh_time_store (
    input  logic                clk,
    input  wlh_pkg::time_req_t  req,
    output wlh_pkg::time_rsp_t  rsp
);

    wlh_pkg::time_rsp_t mem [wlh_pkg::TASK_SLOTS];
    wlh_pkg::time_rsp_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.addr] <= '{valid: req.wr_valid, ts: req.wr_ts};
        end
        if (req.rd_en)
        begin
            rdata_reg <= mem[req.addr];
        end
    end

    assign rsp = rdata_reg;

endmodule

[rtl/wlh_hist_store.sv]
module wlh_hist_store (
    input  logic                clk,
    input  wlh_pkg::hist_req_t  req,
    output wlh_pkg::hist_rsp_t  rsp
);

    logic [wlh_pkg::CNT_W-1:0]               bin_mem [wlh_pkg::BIN_DEPTH];
    logic [wlh_pkg::TS_W+wlh_pkg::CNT_W-1:0] grp_mem [wlh_pkg::GROUPS];

    logic [wlh_pkg::CNT_W-1:0]               bin_rdata_reg;
    logic [wlh_pkg::TS_W+wlh_pkg::CNT_W-1:0] grp_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.bin_wr)
        begin
            bin_mem[req.bin_addr] <= req.bin_wdata;
        end
        if (req.bin_rd)
        begin
            bin_rdata_reg <= bin_mem[req.bin_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.grp_wr)
        begin
            grp_mem[req.grp_addr] <= {req.grp_wsum, req.grp_wcnt};
        end
        if (req.grp_rd)
        begin
            grp_rdata_reg <= grp_mem[req.grp_addr];
        end
    end

    assign rsp.bin_count = bin_rdata_reg;
    assign rsp.grp_sum   = grp_rdata_reg[wlh_pkg::TS_W+wlh_pkg::CNT_W-1:wlh_pkg::CNT_W];
    assign rsp.grp_cnt   = grp_rdata_reg[wlh_pkg::CNT_W-1:0];

endmodule

[rtl/wlh_scale.sv]
module wlh_scale (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        go,
    input  logic                        unit_is_ms,
    input  logic [wlh_pkg::TS_W-1:0]    dividend,
    output logic                        done,
    output wlh_pkg::scale_res_t         res
);

    logic                              run_reg;
    logic                              run_next;
    logic [wlh_pkg::MUL_STEP_W-1:0]    step_reg;
    logic [wlh_pkg::MUL_STEP_W-1:0]    step_next;
    logic                              ms_reg;
    logic [wlh_pkg::TS_W-1:0]          opa_reg;
    logic [wlh_pkg::TS_W-1:0]          opb_reg;
    logic [wlh_pkg::PROD_W-1:0]        acc_reg;
    logic [wlh_pkg::PROD_W-1:0]        acc_next;
    logic [wlh_pkg::MUL_W-1:0]         mul_a;
    logic [wlh_pkg::MUL_W-1:0]         mul_b;
    logic [wlh_pkg::PART_W-1:0]        partial;
    logic [wlh_pkg::PROD_W-1:0]        shifted;
    logic [wlh_pkg::SCALED_W-1:0]      quotient;

    assign done = run_reg && (step_reg == wlh_pkg::MUL_STEP_W'(wlh_pkg::MUL_STEPS - 1));

    // divide by 2^k times an odd factor: shift off 2^k, then multiply by the
    // rounded-up reciprocal of the odd factor, one 32x32 partial product a cycle
    assign mul_a   = step_reg[1] ? opa_reg[wlh_pkg::TS_W-1:wlh_pkg::MUL_W]
                                 : opa_reg[wlh_pkg::MUL_W-1:0];
    assign mul_b   = step_reg[0] ? opb_reg[wlh_pkg::TS_W-1:wlh_pkg::MUL_W]
                                 : opb_reg[wlh_pkg::MUL_W-1:0];
    assign partial = wlh_pkg::PART_W'(mul_a) * wlh_pkg::PART_W'(mul_b);

    always_comb
    begin
        shifted = wlh_pkg::PROD_W'(partial);
        if (step_reg == wlh_pkg::MUL_STEP_W'(wlh_pkg::MUL_STEPS - 1))
            shifted = wlh_pkg::PROD_W'(partial) << wlh_pkg::PART_W;
        else if (step_reg != '0)
            shifted = wlh_pkg::PROD_W'(partial) << wlh_pkg::MUL_W;
    end

    assign acc_next = acc_reg + shifted;

    always_comb
    begin
        run_next  = run_reg;
        step_next = step_reg;
        if (go)
        begin
            run_next  = 1'b1;
            step_next = '0;
        end
        else if (run_reg)
        begin
            step_next = step_reg + 1'b1;
            if (done)
            begin
                run_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            ms_reg  <= unit_is_ms;
            opa_reg <= unit_is_ms ? (dividend >> wlh_pkg::MS_PRE_SHIFT)
                                  : (dividend >> wlh_pkg::US_PRE_SHIFT);
            opb_reg <= unit_is_ms ? wlh_pkg::MS_RECIP : wlh_pkg::US_RECIP;
            acc_reg <= '0;
        end
        else if (run_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    assign quotient = ms_reg ? acc_reg[wlh_pkg::MS_POST_SHIFT +: wlh_pkg::SCALED_W]
                             : acc_reg[wlh_pkg::US_POST_SHIFT +: wlh_pkg::SCALED_W];

    // floor log2 of the quotient, zero maps to bin 0, clamp to the last bin
    always_comb
    begin
        res.quotient = quotient;
        res.bin      = '0;
        for (int b = 1; b < wlh_pkg::BINS - 1; b++)
        begin
            if (quotient[b])
                res.bin = wlh_pkg::BIN_W'(b);
        end
        if (|quotient[wlh_pkg::SCALED_W-1:wlh_pkg::BINS-1])
            res.bin = wlh_pkg::BIN_W'(wlh_pkg::BINS - 1);
    end

endmodule

[rtl/wait_latency_log2_histogram_unit.sv]
// Wait-latency log2 histogram. Items are issued with start while busy is low;
// each one gives exactly one result, shown for a single cycle with done high,
// and the receiver cannot hold it off, so it must take it in that cycle.
// Items other than a measured switch go from accept back to idle through one
// timestamp/histogram memory read, then the decision and write back. A
// measured switch goes through the lookup state, the divider state in which
// one 32x32 multiplier scales the delta to us or ms by a reciprocal, the bin
// counter read, its write back, and the return to idle. After reset busy
// stays high while a clearing pass zeroes the bin, group and slot-valid
// memories; unit_is_ms writes on the cfg channel are taken at any time and
// apply to every item accepted at or after the write's edge.
module wait_latency_log2_histogram_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [wlh_pkg::ACT_W-1:0]       action,
    input  logic [wlh_pkg::TASK_W-1:0]      task_id,
    input  logic [wlh_pkg::TS_W-1:0]        timestamp_ns,
    input  logic [wlh_pkg::GRP_W-1:0]       group,
    input  logic [wlh_pkg::BIN_W-1:0]       bin_select,
    input  logic                            discard,
    output logic                            done,
    output logic [wlh_pkg::STAT_W-1:0]      status,
    output logic [wlh_pkg::BIN_W-1:0]       bin_index,
    output logic [wlh_pkg::SCALED_W-1:0]    scaled_latency,
    output logic [wlh_pkg::CNT_W-1:0]       bin_count,
    output logic [wlh_pkg::TS_W-1:0]        group_total_ns,
    output logic [wlh_pkg::CNT_W-1:0]       group_count,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic                            cfg_data
);

    wlh_pkg::state_t                  state_reg;
    wlh_pkg::state_t                  state_next;
    logic [wlh_pkg::CLR_W-1:0]        clr_reg;
    logic [wlh_pkg::CLR_W-1:0]        clr_next;
    logic                             unit_reg;
    logic                             done_reg;
    logic                             done_next;

    logic [wlh_pkg::ACT_W-1:0]        act_reg;
    logic [wlh_pkg::TASK_W-1:0]       task_reg;
    logic [wlh_pkg::TS_W-1:0]         ts_reg;
    logic [wlh_pkg::GRP_W-1:0]        grp_reg;
    logic [wlh_pkg::BIN_W-1:0]        sel_reg;
    logic                             disc_reg;
    logic [wlh_pkg::TS_W-1:0]         delta_reg;
    logic [wlh_pkg::TS_W-1:0]         delta_next;

    logic [wlh_pkg::STAT_W-1:0]       status_reg;
    logic [wlh_pkg::STAT_W-1:0]       status_next;
    logic [wlh_pkg::BIN_W-1:0]        bin_index_reg;
    logic [wlh_pkg::BIN_W-1:0]        bin_index_next;
    logic [wlh_pkg::SCALED_W-1:0]     scaled_reg;
    logic [wlh_pkg::SCALED_W-1:0]     scaled_next;
    logic [wlh_pkg::CNT_W-1:0]        bin_count_reg;
    logic [wlh_pkg::CNT_W-1:0]        bin_count_next;
    logic [wlh_pkg::TS_W-1:0]         total_reg;
    logic [wlh_pkg::TS_W-1:0]         total_next;
    logic [wlh_pkg::CNT_W-1:0]        gcount_reg;
    logic [wlh_pkg::CNT_W-1:0]        gcount_next;

    logic                             accept;
    logic                             task_ok;
    logic                             grp_ok;
    logic                             grp_in_ok;
    logic                             measure_go;
    logic [wlh_pkg::TS_W-1:0]         delta;
    logic                             scale_go;
    logic                             scale_done;

    wlh_pkg::time_req_t               time_req;
    wlh_pkg::time_rsp_t               time_rsp;
    wlh_pkg::hist_req_t               hist_req;
    wlh_pkg::hist_rsp_t               hist_rsp;
    wlh_pkg::scale_res_t              scale_res;

    wlh_time_store u_time_store (
        .clk (clk),
        .req (time_req),
        .rsp (time_rsp)
    );

    wlh_hist_store u_hist_store (
        .clk (clk),
        .req (hist_req),
        .rsp (hist_rsp)
    );

    wlh_scale u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .go         (scale_go),
        .unit_is_ms (unit_reg),
        .dividend   (delta),
        .done       (scale_done),
        .res        (scale_res)
    );

    assign busy      = (state_reg != wlh_pkg::S_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;

    assign task_ok    = (task_reg != '0) && (32'(task_reg) < wlh_pkg::TASK_SLOTS);
    assign grp_ok     = 32'(grp_reg) < wlh_pkg::GROUPS;
    assign grp_in_ok  = 32'(group) < wlh_pkg::GROUPS;
    assign delta      = ts_reg - time_rsp.ts;
    assign measure_go = (act_reg == wlh_pkg::ACT_SWITCH) && task_ok && time_rsp.valid
                        && !disc_reg && grp_ok;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            wlh_pkg::S_CLEAR:
            begin
                if (clr_reg == wlh_pkg::CLR_W'(wlh_pkg::CLEAR_LEN - 1))
                    state_next = wlh_pkg::S_IDLE;
            end
            wlh_pkg::S_IDLE:
            begin
                if (accept)
                    state_next = wlh_pkg::S_LOOK;
            end
            wlh_pkg::S_LOOK:
            begin
                state_next = measure_go ? wlh_pkg::S_DIV : wlh_pkg::S_IDLE;
            end
            wlh_pkg::S_DIV:
            begin
                if (scale_done)
                    state_next = wlh_pkg::S_BIN_RD;
            end
            wlh_pkg::S_BIN_RD:
            begin
                state_next = wlh_pkg::S_UPDATE;
            end
            wlh_pkg::S_UPDATE:
            begin
                state_next = wlh_pkg::S_IDLE;
            end
            default:
            begin
                state_next = wlh_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        time_req       = '0;
        hist_req       = '0;
        scale_go       = 1'b0;
        clr_next       = clr_reg;
        delta_next     = delta_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        bin_index_next = bin_index_reg;
        scaled_next    = scaled_reg;
        bin_count_next = bin_count_reg;
        total_next     = total_reg;
        gcount_next    = gcount_reg;

        case (state_reg)
            wlh_pkg::S_CLEAR:
            begin
                time_req.wr_en    = 32'(clr_reg) < wlh_pkg::TASK_SLOTS;
                time_req.addr     = wlh_pkg::TASK_AW'(clr_reg);
                hist_req.bin_wr   = 32'(clr_reg) < wlh_pkg::BIN_DEPTH;
                hist_req.bin_addr = wlh_pkg::BIN_AW'(clr_reg);
                hist_req.grp_wr   = 32'(clr_reg) < wlh_pkg::GROUPS;
                hist_req.grp_addr = wlh_pkg::GRP_AW'(clr_reg);
                clr_next          = clr_reg + 1'b1;
            end
            wlh_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    time_req.rd_en    = 1'b1;
                    time_req.addr     = wlh_pkg::TASK_AW'(task_id);
                    hist_req.grp_rd   = grp_in_ok;
                    hist_req.grp_addr = wlh_pkg::GRP_AW'(group);
                    hist_req.bin_rd   = grp_in_ok && (action == wlh_pkg::ACT_READ);
                    hist_req.bin_addr = wlh_pkg::bin_addr(group,
                                                          wlh_pkg::clamp_bin(bin_select));
                end
            end
            wlh_pkg::S_LOOK:
            begin
                done_next      = !measure_go;
                status_next    = wlh_pkg::STAT_IGNORED;
                bin_index_next = '0;
                scaled_next    = '0;
                bin_count_next = '0;
                total_next     = '0;
                gcount_next    = '0;
                time_req.addr  = wlh_pkg::TASK_AW'(task_reg);
                time_req.wr_ts = ts_reg;
                case (act_reg)
                    wlh_pkg::ACT_WAKEUP:
                    begin
                        if (task_ok)
                        begin
                            time_req.wr_en    = 1'b1;
                            time_req.wr_valid = 1'b1;
                            status_next       = wlh_pkg::STAT_RECORDED;
                        end
                    end
                    wlh_pkg::ACT_SWITCH:
                    begin
                        if (task_ok && !time_rsp.valid)
                        begin
                            status_next = wlh_pkg::STAT_NO_START;
                        end
                        else if (task_ok)
                        begin
                            // drop the start mark even if the switch is not counted
                            time_req.wr_en = 1'b1;
                            delta_next     = delta;
                            scale_go       = measure_go;
                        end
                    end
                    wlh_pkg::ACT_READ:
                    begin
                        status_next    = wlh_pkg::STAT_READ;
                        bin_index_next = wlh_pkg::clamp_bin(sel_reg);
                        if (grp_ok)
                        begin
                            bin_count_next = hist_rsp.bin_count;
                            total_next     = hist_rsp.grp_sum;
                            gcount_next    = hist_rsp.grp_cnt;
                        end
                    end
                    default:
                    begin
                        status_next = wlh_pkg::STAT_IGNORED;
                    end
                endcase
            end
            wlh_pkg::S_DIV:
            begin
                scale_go = 1'b0;
            end
            wlh_pkg::S_BIN_RD:
            begin
                hist_req.bin_rd   = 1'b1;
                hist_req.bin_addr = wlh_pkg::bin_addr(grp_reg, scale_res.bin);
            end
            wlh_pkg::S_UPDATE:
            begin
                hist_req.bin_wr    = 1'b1;
                hist_req.bin_addr  = wlh_pkg::bin_addr(grp_reg, scale_res.bin);
                hist_req.bin_wdata = hist_rsp.bin_count + 1'b1;
                hist_req.grp_wr    = 1'b1;
                hist_req.grp_addr  = wlh_pkg::GRP_AW'(grp_reg);
                hist_req.grp_wsum  = hist_rsp.grp_sum + delta_reg;
                hist_req.grp_wcnt  = hist_rsp.grp_cnt + 1'b1;
                done_next          = 1'b1;
                status_next        = wlh_pkg::STAT_MEASURED;
                bin_index_next     = scale_res.bin;
                scaled_next        = scale_res.quotient;
                bin_count_next     = hist_req.bin_wdata;
                total_next         = hist_req.grp_wsum;
                gcount_next        = hist_req.grp_wcnt;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wlh_pkg::S_CLEAR;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
            unit_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            done_reg  <= done_next;
            if (cfg_valid && cfg_ready)
                unit_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg  <= action;
            task_reg <= task_id;
            ts_reg   <= timestamp_ns;
            grp_reg  <= group;
            sel_reg  <= bin_select;
            disc_reg <= discard;
        end
        delta_reg     <= delta_next;
        status_reg    <= status_next;
        bin_index_reg <= bin_index_next;
        scaled_reg    <= scaled_next;
        bin_count_reg <= bin_count_next;
        total_reg     <= total_next;
        gcount_reg    <= gcount_next;
    end

    assign done           = done_reg;
    assign status         = status_reg;
    assign bin_index      = bin_index_reg;
    assign scaled_latency = scaled_reg;
    assign bin_count      = bin_count_reg;
    assign group_total_ns = total_reg;
    assign group_count    = gcount_reg;

    a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == wlh_pkg::S_CLEAR |-> !done_reg)
        else $error("result strobe during clearing pass");

    a_accept_to_look: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == wlh_pkg::S_LOOK)
        else $error("accepted transaction did not reach lookup");

    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(state_reg) == wlh_pkg::S_LOOK
                      || $past(state_reg) == wlh_pkg::S_UPDATE))
        else $error("result strobe from unexpected state");

    a_scaled_only_measured: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && status_reg != wlh_pkg::STAT_MEASURED |-> scaled_reg == '0)
        else $error("scaled latency set on a non-measure result");

    a_divider_finishes: assert property (@(posedge clk) disable iff (!rst_n)
        scale_done |-> state_reg == wlh_pkg::S_DIV)
        else $error("divider finished outside its state");

endmodule

[tb/wlh_checker.sv]
`timescale 1ns / 100ps

module wlh_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic                            busy,
    input  logic [wlh_pkg::ACT_W-1:0]       action,
    input  logic [wlh_pkg::TASK_W-1:0]      task_id,
    input  logic [wlh_pkg::TS_W-1:0]        timestamp_ns,
    input  logic [wlh_pkg::GRP_W-1:0]       group,
    input  logic [wlh_pkg::BIN_W-1:0]       bin_select,
    input  logic                            discard,
    input  logic                            done,
    input  logic [wlh_pkg::STAT_W-1:0]      status,
    input  logic [wlh_pkg::BIN_W-1:0]       bin_index,
    input  logic [wlh_pkg::SCALED_W-1:0]    scaled_latency,
    input  logic [wlh_pkg::CNT_W-1:0]       bin_count,
    input  logic [wlh_pkg::TS_W-1:0]        group_total_ns,
    input  logic [wlh_pkg::CNT_W-1:0]       group_count,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic                            cfg_data,
    output int                              fail_count,
    output int                              pending,
    output int                              results_checked,
    output int                              measured_count
);
    import wlh_pkg::*;

    typedef struct packed {
        logic [STAT_W-1:0]   status;
        logic [BIN_W-1:0]    bin;
        logic [SCALED_W-1:0] scaled;
        logic [CNT_W-1:0]    bin_cnt;
        logic [TS_W-1:0]     sum_ns;
        logic [CNT_W-1:0]    events;
    } hist_result_t;

    logic [TS_W-1:0]  wake_time  [TASK_SLOTS];
    logic             wake_valid [TASK_SLOTS];
    logic [CNT_W-1:0] bin_tally  [BIN_DEPTH];
    logic [TS_W-1:0]  grp_total  [GROUPS];
    logic [CNT_W-1:0] grp_events [GROUPS];
    logic             use_ms;

    hist_result_t expected_q [$];
    int fails;
    int checked;
    int measured;

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fails++;
        end
    endtask

    task automatic predict_item(input logic [ACT_W-1:0] act, input logic [TASK_W-1:0] tid,
                                input logic [TS_W-1:0] ts, input logic [GRP_W-1:0] grp,
                                input logic [BIN_W-1:0] sel, input logic disc,
                                output hist_result_t res);
        logic [TS_W-1:0] delta;
        logic [TS_W-1:0] scaled;
        int lead;
        int idx;
        int b;
        res = '0;
        res.status = STAT_IGNORED;
        if ((act == ACT_WAKEUP || act == ACT_SWITCH) && tid != '0 && int'(tid) < TASK_SLOTS)
        begin
            if (act == ACT_WAKEUP)
            begin
                wake_time[tid] = ts;
                wake_valid[tid] = 1'b1;
                res.status = STAT_RECORDED;
            end
            else if (!wake_valid[tid])
            begin
                res.status = STAT_NO_START;
            end
            else
            begin
                delta = ts - wake_time[tid];
                // the slot clears even when the measurement is dropped
                wake_valid[tid] = 1'b0;
                if (!disc && int'(grp) < GROUPS)
                begin
                    scaled = use_ms ? delta / 64'(NS_PER_MS) : delta / 64'(NS_PER_US);
                    lead = 0;
                    for (b = 0; b < TS_W; b++)
                        if (scaled[b])
                            lead = b;
                    if (lead >= BINS)
                        lead = BINS - 1;
                    idx = int'(grp) * BINS + lead;
                    bin_tally[idx] += 1;
                    grp_total[grp] += delta;
                    grp_events[grp] += 1;
                    res.status = STAT_MEASURED;
                    res.bin = BIN_W'(lead);
                    res.scaled = scaled[SCALED_W-1:0];
                    res.bin_cnt = bin_tally[idx];
                    res.sum_ns = grp_total[grp];
                    res.events = grp_events[grp];
                end
            end
        end
        else if (act == ACT_READ)
        begin
            lead = (int'(sel) >= BINS) ? BINS - 1 : int'(sel);
            res.status = STAT_READ;
            res.bin = BIN_W'(lead);
            if (int'(grp) < GROUPS)
            begin
                res.bin_cnt = bin_tally[int'(grp) * BINS + lead];
                res.sum_ns = grp_total[grp];
                res.events = grp_events[grp];
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        hist_result_t want;
        hist_result_t fresh;
        int i;
        if (!rst_n)
        begin
            for (i = 0; i < TASK_SLOTS; i++)
            begin
                wake_time[i] = '0;
                wake_valid[i] = 1'b0;
            end
            for (i = 0; i < BIN_DEPTH; i++)
                bin_tally[i] = '0;
            for (i = 0; i < GROUPS; i++)
            begin
                grp_total[i] = '0;
                grp_events[i] = '0;
            end
            use_ms = 1'b0;
            expected_q.delete();
            fails = 0;
            checked = 0;
            measured = 0;
            fail_count <= 0;
            pending <= 0;
            results_checked <= 0;
            measured_count <= 0;
        end
        else
        begin
            // retire the oldest transaction before taking a new one at the same edge
            if (done)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: result with nothing outstanding, expected none, actual status %0d",
                             $time, status);
                    fails++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    compare_field("status", 64'(want.status), 64'(status));
                    compare_field("bin_index", 64'(want.bin), 64'(bin_index));
                    compare_field("scaled_latency", 64'(want.scaled), 64'(scaled_latency));
                    compare_field("bin_count", want.bin_cnt, bin_count);
                    compare_field("group_total_ns", want.sum_ns, group_total_ns);
                    compare_field("group_count", want.events, group_count);
                    checked++;
                end
            end
            if (cfg_valid && cfg_ready)
                use_ms = cfg_data;
            if (start && !busy)
            begin
                predict_item(action, task_id, timestamp_ns, group, bin_select, discard, fresh);
                if (fresh.status == STAT_MEASURED)
                    measured++;
                expected_q.push_back(fresh);
            end
            fail_count <= fails;
            pending <= expected_q.size();
            results_checked <= checked;
            measured_count <= measured;
        end
    end

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps

module testbench;
    import wlh_pkg::*;

    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
    localparam int PHASE_ITEMS  = 450;
    localparam int DRAIN_CYCLES = 25;
    localparam int CYCLE_LIMIT  = 400000;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [ACT_W-1:0]    action = '0;
    logic [TASK_W-1:0]   task_id = '0;
    logic [TS_W-1:0]     timestamp_ns = '0;
    logic [GRP_W-1:0]    group = '0;
    logic [BIN_W-1:0]    bin_select = '0;
    logic                discard = 1'b0;
    logic                done;
    logic [STAT_W-1:0]   status;
    logic [BIN_W-1:0]    bin_index;
    logic [SCALED_W-1:0] scaled_latency;
    logic [CNT_W-1:0]    bin_count;
    logic [TS_W-1:0]     group_total_ns;
    logic [CNT_W-1:0]    group_count;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic                cfg_data = 1'b0;

    int fail_count;
    int pending;
    int results_checked;
    int measured_count;

    // stimulus bookkeeping only: which slots hold a wakeup, and when
    bit              slot_open  [TASK_SLOTS];
    logic [TS_W-1:0] wake_stamp [TASK_SLOTS];
    int              open_q [$];
    bit              burst = 1'b0;
    int              items_sent = 0;
    int              cycle_count = 0;

    always #5 clk = ~clk;

    wait_latency_log2_histogram_unit DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .action         (action),
        .task_id        (task_id),
        .timestamp_ns   (timestamp_ns),
        .group          (group),
        .bin_select     (bin_select),
        .discard        (discard),
        .done           (done),
        .status         (status),
        .bin_index      (bin_index),
        .scaled_latency (scaled_latency),
        .bin_count      (bin_count),
        .group_total_ns (group_total_ns),
        .group_count    (group_count),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    wlh_checker hist_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .action          (action),
        .task_id         (task_id),
        .timestamp_ns    (timestamp_ns),
        .group           (group),
        .bin_select      (bin_select),
        .discard         (discard),
        .done            (done),
        .status          (status),
        .bin_index       (bin_index),
        .scaled_latency  (scaled_latency),
        .bin_count       (bin_count),
        .group_total_ns  (group_total_ns),
        .group_count     (group_count),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending         (pending),
        .results_checked (results_checked),
        .measured_count  (measured_count)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d transactions outstanding", $time, pending);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic logic [TASK_W-1:0] pick_task();
        int r;
        r = $urandom_range(0, 9);
        if (r < 8)
            return TASK_W'($urandom_range(1, 24));
        else if (r == 8)
            return TASK_W'($urandom);
        else
            return ($urandom_range(0, 1) == 0) ? TASK_W'(0) : TASK_W'(TASK_SLOTS - 1);
    endfunction

    function automatic logic [GRP_W-1:0] pick_group();
        if ($urandom_range(0, 4) != 0)
            return GRP_W'($urandom_range(0, 7));
        return GRP_W'($urandom);
    endfunction

    task automatic send_item(input logic [ACT_W-1:0] act, input logic [TASK_W-1:0] tid,
                             input logic [TS_W-1:0] ts, input logic [GRP_W-1:0] grp,
                             input logic [BIN_W-1:0] sel, input logic disc);
        int gap;
        int i;
        gap = burst ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        action <= act;
        task_id <= tid;
        timestamp_ns <= ts;
        group <= grp;
        bin_select <= sel;
        discard <= disc;
        do
            @(posedge clk);
        while (busy);
        items_sent++;
        if (tid != '0 && act == ACT_WAKEUP)
        begin
            if (!slot_open[tid])
                open_q.push_back(int'(tid));
            slot_open[tid] = 1'b1;
            wake_stamp[tid] = ts;
        end
        else if (tid != '0 && act == ACT_SWITCH && slot_open[tid])
        begin
            slot_open[tid] = 1'b0;
            for (i = 0; i < open_q.size(); i++)
                if (open_q[i] == int'(tid))
                begin
                    open_q.delete(i);
                    break;
                end
        end
    endtask

    // hold start low and let every outstanding transaction come back
    task automatic drain_block();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_unit(input logic ms);
        drain_block();
        cfg_valid <= 1'b1;
        cfg_data <= ms;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic ms);
        int n;
        int pick;
        int k;
        logic [TASK_W-1:0] tid;
        logic [TS_W-1:0]   ts;
        logic [TS_W-1:0]   delta;
        set_unit(ms);
        for (n = 0; n < PHASE_ITEMS; n++)
        begin
            // alternate stretches of back-to-back items with randomly gapped ones
            if (n % 60 == 0)
                burst = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 35)
            begin
                send_item(ACT_WAKEUP, pick_task(), {$urandom, $urandom}, pick_group(),
                          BIN_W'($urandom), 1'($urandom));
            end
            else if (pick < 75)
            begin
                if (open_q.size() > 0 && $urandom_range(0, 9) != 0)
                begin
                    tid = TASK_W'(open_q[$urandom_range(0, open_q.size() - 1)]);
                    if ($urandom_range(0, 4) == 0)
                    begin
                        // land just around a bin edge
                        k = $urandom_range(0, 28);
                        delta = ((ms ? 64'(NS_PER_MS) : 64'(NS_PER_US)) << k)
                                + 64'($urandom_range(0, 2)) - 64'd1;
                    end
                    else
                    begin
                        k = $urandom_range(0, 63);
                        delta = {$urandom, $urandom} >> k;
                    end
                    ts = wake_stamp[tid] + delta;
                end
                else
                begin
                    tid = pick_task();
                    ts = {$urandom, $urandom};
                end
                send_item(ACT_SWITCH, tid, ts, pick_group(), BIN_W'($urandom),
                          ($urandom_range(0, 9) == 0));
            end
            else if (pick < 95)
            begin
                send_item(ACT_READ, pick_task(), {$urandom, $urandom}, pick_group(),
                          BIN_W'($urandom_range(0, 31)), 1'($urandom));
            end
            else
            begin
                send_item(ACT_UNUSED, pick_task(), {$urandom, $urandom}, pick_group(),
                          BIN_W'($urandom), 1'($urandom));
            end
        end
        burst = 1'b0;
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        set_unit(1'b0);
        send_item(ACT_WAKEUP, '0, 64'd5, '0, '0, 1'b0);
        send_item(ACT_SWITCH, '0, 64'd9, '0, '0, 1'b0);
        send_item(ACT_SWITCH, 10'd5, 64'd100, '0, '0, 1'b0);
        send_item(ACT_UNUSED, 10'd7, '1, '1, '1, 1'b1);
        send_item(ACT_READ, '0, '0, '0, '0, 1'b0);
        send_item(ACT_READ, '1, '1, '1, '1, 1'b1);
        // zero delta into the top group
        send_item(ACT_WAKEUP, '1, '0, '1, '0, 1'b0);
        send_item(ACT_SWITCH, '1, '0, '1, '0, 1'b0);
        // delta wraps through zero
        send_item(ACT_WAKEUP, 10'd1, '1, '0, '0, 1'b0);
        send_item(ACT_SWITCH, 10'd1, 64'd999, '0, '0, 1'b0);
        // largest delta clamps to the last bin
        send_item(ACT_WAKEUP, 10'd2, '0, 6'd1, '0, 1'b0);
        send_item(ACT_SWITCH, 10'd2, '1, 6'd1, '0, 1'b0);
        // discarded switch still clears the slot
        send_item(ACT_WAKEUP, 10'd3, 64'd500, '0, '0, 1'b0);
        send_item(ACT_SWITCH, 10'd3, 64'd9000, '0, '0, 1'b1);
        send_item(ACT_SWITCH, 10'd3, 64'd9500, '0, '0, 1'b0);
        // second wakeup overwrites the first
        send_item(ACT_WAKEUP, 10'd4, 64'd100, '0, '0, 1'b0);
        send_item(ACT_WAKEUP, 10'd4, 64'd1100, '0, '0, 1'b0);
        send_item(ACT_SWITCH, 10'd4, 64'd3100, '0, '0, 1'b0);
        send_item(ACT_READ, '0, '0, '0, '0, 1'b0);
        send_item(ACT_READ, '0, '0, 6'd1, 5'd26, 1'b0);
        send_item(ACT_READ, '0, '0, '1, '0, 1'b0);
        send_item(ACT_READ, '0, '0, 6'd1, 5'd27, 1'b0);

        run_phase(1'b1);
        run_phase(1'b0);
        run_phase(1'b1);
        run_phase(1'b0);
        drain_block();

        $display("Run covered %0d items, directed corner cases then random traffic", items_sent);
        $display("over both latency units: %0d results checked, %0d of them measurements",
                 results_checked, measured_count);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
